### rtl/wsor_pkg.sv
package wsor_pkg;

   localparam int VALUE_BITS_DEF = 24;
   localparam int TIME_BITS_DEF  = 31;

   // window geometry
   localparam int WIN    = 5;
   localparam int HALF   = WIN / 2;
   localparam int SLOTS  = WIN - HALF;
   localparam int NPAIRS = WIN * (WIN - 1) / 2;

   localparam int PAIR_A [NPAIRS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
   localparam int PAIR_B [NPAIRS] = '{1, 2, 3, 4, 2, 3, 4, 3, 4, 4};

   // test pipeline and result queue
   localparam int PIPE_STAGES = 6;
   localparam int QDEPTH      = 8;
   localparam int QAW         = $clog2(QDEPTH);

   typedef logic [SLOTS-1:0] wsor_mask_type;

   localparam wsor_mask_type BEAT_CENTER = 3'b001;
   localparam wsor_mask_type BEAT_NEXT   = 3'b010;
   localparam wsor_mask_type BEAT_NEWEST = 3'b100;

   typedef struct packed {
      logic valid;
      logic emit2;
      logic test;
      logic has3;
      logic last;
   } wsor_ctl_type;

endpackage

### rtl/wsor_cell.sv
module wsor_cell #(
   parameter int VALUE_BITS = 24,
   parameter int TIME_BITS  = 31
) (
   input  logic                         clock,
   input  logic                         shift,
   input  logic signed [VALUE_BITS-1:0] next_value,
   input  logic        [TIME_BITS-1:0]  next_time,
   output logic signed [VALUE_BITS-1:0] cell_value,
   output logic        [TIME_BITS-1:0]  cell_time
);

   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic        [TIME_BITS-1:0]  time_ff, time_in;

   // load from the neighbor on a shift, hold otherwise
   always_comb begin
      value_in = shift ? next_value : value_ff;
      time_in  = shift ? next_time : time_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      time_ff  <= time_in;
   end

   assign cell_value = value_ff;
   assign cell_time  = time_ff;

endmodule

### rtl/wsor_square.sv
module wsor_square #(
   parameter int W = 25
) (
   input  logic                clock,
   input  logic signed [W-1:0] a,
   output logic [2*W-1:0]      sq
);

   localparam int LW = (W + 1) / 2;
   localparam int HW = W - LW;

   logic [W-1:0]       mag;
   logic [2*HW-1:0]    hh_ff, hh_in;
   logic [HW+LW-1:0]   hl_ff, hl_in;
   logic [2*LW-1:0]    ll_ff, ll_in;
   logic [2*W-1:0]     sq_ff, sq_in;

   // split the magnitude in halves, three narrow products
   always_comb begin
      mag   = a[W-1] ? (~a + W'(1)) : a;
      hh_in = (2*HW)'(mag[W-1:LW]) * (2*HW)'(mag[W-1:LW]);
      hl_in = (HW+LW)'(mag[W-1:LW]) * (HW+LW)'(mag[LW-1:0]);
      ll_in = (2*LW)'(mag[LW-1:0]) * (2*LW)'(mag[LW-1:0]);
      sq_in = ((2*W)'(hh_ff) << (2*LW)) + ((2*W)'(hl_ff) << (LW+1)) + (2*W)'(ll_ff);
   end

   always_ff @(posedge clock) begin
      hh_ff <= hh_in;
      hl_ff <= hl_in;
      ll_ff <= ll_in;
      sq_ff <= sq_in;
   end

   assign sq = sq_ff;

endmodule

### rtl/wsor_test.sv
module wsor_test
   import wsor_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wsor_ctl_type                 in_ctl,
   input  logic signed [VALUE_BITS-1:0] win_value [WIN],
   input  logic        [TIME_BITS-1:0]  slot_time [SLOTS],
   input  logic signed [VALUE_BITS-1:0] slot_value [SLOTS],
   output wsor_ctl_type                 out_ctl,
   output logic                         out_drop,
   output logic        [TIME_BITS-1:0]  out_time [SLOTS],
   output logic signed [VALUE_BITS-1:0] out_value [SLOTS]
);

   localparam int DW = VALUE_BITS + 1;
   localparam int EW = VALUE_BITS + 3;
   localparam int CW = 2 * VALUE_BITS + 4;
   localparam int NP = NPAIRS / 2;

   logic signed [DW-1:0] diff_in [NPAIRS];
   logic signed [DW-1:0] diff_ff [NPAIRS];
   logic signed [EW-1:0] dev_in, dev_ff, dev_sum;
   logic [2*DW-1:0]      dsq [NPAIRS];
   logic [2*EW-1:0]      esq;
   logic [CW-1:0]        psum_ff [NP];
   logic [CW-1:0]        qsum_ff [3];
   logic [CW-1:0]        rsum_ff, lsq4_ff, lsq5_ff, lsq6_ff;

   wsor_ctl_type                 ctl_ff [PIPE_STAGES];
   logic        [TIME_BITS-1:0]  time_ff [PIPE_STAGES][SLOTS];
   logic signed [VALUE_BITS-1:0] value_ff [PIPE_STAGES][SLOTS];

   // pairwise differences and 5x - S of the centre
   always_comb begin
      dev_sum = '0;
      for (int p = 0; p < NPAIRS; p++) begin
         diff_in[p] = DW'(win_value[PAIR_A[p]]) - DW'(win_value[PAIR_B[p]]);
      end
      for (int i = 0; i < WIN; i++) begin
         if (i != HALF) dev_sum = dev_sum + EW'(win_value[i]);
      end
      dev_in = (EW'(win_value[HALF]) <<< 2) - dev_sum;
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      dev_ff  <= dev_in;
   end

   for (genvar p = 0; p < NPAIRS; p++) begin : g_dsq
      wsor_square #(.W(DW)) u_sq (.clock(clock), .a(diff_ff[p]), .sq(dsq[p]));
   end

   wsor_square #(.W(EW)) u_esq (.clock(clock), .a(dev_ff), .sq(esq));

   // reduce the ten squares over three stages
   always_ff @(posedge clock) begin
      for (int m = 0; m < NP; m++) begin
         psum_ff[m] <= CW'(dsq[2*m]) + CW'(dsq[2*m+1]);
      end
      lsq4_ff    <= CW'(esq);
      qsum_ff[0] <= psum_ff[0] + psum_ff[1];
      qsum_ff[1] <= psum_ff[2] + psum_ff[3];
      qsum_ff[2] <= psum_ff[4];
      lsq5_ff    <= lsq4_ff;
      rsum_ff    <= qsum_ff[0] + qsum_ff[1] + qsum_ff[2];
      lsq6_ff    <= lsq5_ff;
   end

   assign out_drop = (lsq6_ff >= rsum_ff);

   // control and payload ride alongside the arithmetic
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_STAGES; s++) ctl_ff[s] <= '0;
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int s = 1; s < PIPE_STAGES; s++) ctl_ff[s] <= ctl_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      time_ff[0]  <= slot_time;
      value_ff[0] <= slot_value;
      for (int s = 1; s < PIPE_STAGES; s++) begin
         time_ff[s]  <= time_ff[s-1];
         value_ff[s] <= value_ff[s-1];
      end
   end

   assign out_ctl   = ctl_ff[PIPE_STAGES-1];
   assign out_time  = time_ff[PIPE_STAGES-1];
   assign out_value = value_ff[PIPE_STAGES-1];

endmodule

### rtl/wsor_out.sv
module wsor_out
   import wsor_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  wsor_mask_type                wr_mask,
   input  logic        [TIME_BITS-1:0]  wr_time [SLOTS],
   input  logic signed [VALUE_BITS-1:0] wr_value [SLOTS],
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic        [TIME_BITS-1:0]  rsp_kept_time,
   output logic signed [VALUE_BITS-1:0] rsp_kept_value,
   output logic                         rsp_series_done,
   output logic                         retire
);

   wsor_mask_type                mask_ff [QDEPTH];
   logic        [TIME_BITS-1:0]  qtime_ff [QDEPTH][SLOTS];
   logic signed [VALUE_BITS-1:0] qvalue_ff [QDEPTH][SLOTS];

   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;
   wsor_mask_type  sent_ff, sent_in;
   wsor_mask_type  pend, cur, rest;
   logic [1:0]     sel;
   logic           fire;

   always_comb begin
      pend = mask_ff[rd_ptr_ff] & ~sent_ff;
      cur  = pend & (~pend + SLOTS'(1));
      rest = pend & ~cur;
      case (cur)
         BEAT_CENTER: sel = 2'd0;
         BEAT_NEXT:   sel = 2'd1;
         default:     sel = 2'd2;
      endcase
      rsp_valid       = (count_ff != '0);
      rsp_kept_time   = qtime_ff[rd_ptr_ff][sel];
      rsp_kept_value  = qvalue_ff[rd_ptr_ff][sel];
      rsp_series_done = (cur == BEAT_NEWEST);
      fire            = rsp_valid && rsp_ready;
      retire          = fire && (rest == '0);
      // advance past the sent beat, drop the entry after its last one
      if (retire)    sent_in = '0;
      else if (fire) sent_in = sent_ff | cur;
      else           sent_in = sent_ff;
      wr_ptr_in = wr_en ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = retire ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QAW+1)'(wr_en) - (QAW+1)'(retire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sent_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sent_ff   <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mask_ff[wr_ptr_ff]   <= wr_mask;
         qtime_ff[wr_ptr_ff]  <= wr_time;
         qvalue_ff[wr_ptr_ff] <= wr_value;
      end
   end

endmodule

### rtl/window_sigma_outlier_reject.sv
// Five-sample sigma clipping on a stream of timestamped samples. Each sample
// that has two neighbors on each side within its series is dropped when
// (5x - S)^2 >= 5Q - S^2 over the window centred on it (S sum, Q sum of
// squares, the exact form of |x - mean| >= population deviation), so a window
// of equal values drops its centre. The first two and the last two samples of
// a series always pass; a series shorter than five passes whole. Results lag
// the input by two samples, and the beat with req_end_of_series set flushes
// the remaining ones, the final result carrying rsp_series_done. The block
// takes one sample per cycle as long as results drain; a series end yields up
// to three result beats, sent one per cycle while rsp_ready is high, and up to
// eight samples may be outstanding before req_ready drops. The first result of
// a sample passes through the six-stage test pipeline and then the result
// queue before it appears on the response port.
module window_sigma_outlier_reject
   import wsor_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic        [TIME_BITS-1:0]  req_sample_time,
   input  logic signed [VALUE_BITS-1:0] req_sample_value,
   input  logic                         req_end_of_series,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic        [TIME_BITS-1:0]  rsp_kept_time,
   output logic signed [VALUE_BITS-1:0] rsp_kept_value,
   output logic                         rsp_series_done
);

   // Window cells: cell k holds the sample k places after the oldest held, so the
   // window tested with a beat is the four cells and then the incoming sample.
   logic signed [VALUE_BITS-1:0] cell_value [WIN-1];
   logic        [TIME_BITS-1:0]  cell_time [WIN-1];
   logic signed [VALUE_BITS-1:0] win_value [WIN];
   logic        [TIME_BITS-1:0]  slot_time [SLOTS];
   logic signed [VALUE_BITS-1:0] slot_value [SLOTS];

   logic         accept;
   logic [2:0]   fill_ff, fill_in, seen;
   logic [QAW:0] occ_ff, occ_in;
   wsor_ctl_type in_ctl, out_ctl;
   logic         test_drop, retire, wr_en, free;
   wsor_mask_type                wr_mask;
   logic        [TIME_BITS-1:0]  out_time [SLOTS];
   logic signed [VALUE_BITS-1:0] out_value [SLOTS];

   // Hold the input whenever the queue plus pipeline could not take one more
   // sample's results; the count covers every sample not yet fully sent.
   assign req_ready = (occ_ff < (QAW+1)'(QDEPTH));
   assign accept    = req_valid && req_ready;

   for (genvar k = 0; k < WIN - 1; k++) begin : g_cell
      if (k == WIN - 2) begin : g_head
         wsor_cell #(.VALUE_BITS(VALUE_BITS), .TIME_BITS(TIME_BITS)) u_cell (
            .clock(clock), .shift(accept),
            .next_value(req_sample_value), .next_time(req_sample_time),
            .cell_value(cell_value[k]), .cell_time(cell_time[k]));
      end else begin : g_body
         wsor_cell #(.VALUE_BITS(VALUE_BITS), .TIME_BITS(TIME_BITS)) u_cell (
            .clock(clock), .shift(accept),
            .next_value(cell_value[k+1]), .next_time(cell_time[k+1]),
            .cell_value(cell_value[k]), .cell_time(cell_time[k]));
      end
   end

   // Window as it stands once this beat is taken; the last SLOTS entries are
   // the centre, its successor and the newest sample, the ones that may leave.
   always_comb begin
      for (int i = 0; i < WIN - 1; i++) win_value[i] = cell_value[i];
      win_value[WIN-1] = req_sample_value;
      for (int s = 0; s < SLOTS; s++) begin
         if (HALF + s < WIN - 1) begin
            slot_time[s]  = cell_time[HALF+s];
            slot_value[s] = cell_value[HALF+s];
         end else begin
            slot_time[s]  = req_sample_time;
            slot_value[s] = req_sample_value;
         end
      end
   end

   // Series position: count samples of this series, saturate at the window
   // size, restart after the series end.
   always_comb begin
      seen = (fill_ff == 3'(WIN)) ? fill_ff : fill_ff + 3'(1);
      if (accept) fill_in = req_end_of_series ? 3'(0) : seen;
      else        fill_in = fill_ff;
      in_ctl.valid = accept;
      in_ctl.emit2 = (seen > 3'(HALF));
      in_ctl.test  = (seen == 3'(WIN));
      in_ctl.has3  = req_end_of_series && (seen >= 3'(HALF));
      in_ctl.last  = req_end_of_series;
   end

   wsor_test #(.VALUE_BITS(VALUE_BITS), .TIME_BITS(TIME_BITS)) u_test (
      .clock(clock), .reset(reset), .in_ctl(in_ctl), .win_value(win_value),
      .slot_time(slot_time), .slot_value(slot_value), .out_ctl(out_ctl),
      .out_drop(test_drop), .out_time(out_time), .out_value(out_value));

   // Build the beat mask of a finished sample: the centre when one exists and
   // the test kept it; at a series end also any successor and the newest sample.
   // A sample with no beat frees its place right here.
   always_comb begin
      wr_mask = '0;
      if (out_ctl.emit2 && !(out_ctl.test && test_drop)) wr_mask = wr_mask | BEAT_CENTER;
      if (out_ctl.has3) wr_mask = wr_mask | BEAT_NEXT;
      if (out_ctl.last) wr_mask = wr_mask | BEAT_NEWEST;
      wr_en  = out_ctl.valid && (wr_mask != '0);
      free   = out_ctl.valid && (wr_mask == '0);
      occ_in = occ_ff + (QAW+1)'(accept) - (QAW+1)'(free) - (QAW+1)'(retire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         occ_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         occ_ff  <= occ_in;
      end
   end

   // Queue the results and send them out one beat at a time.
   wsor_out #(.VALUE_BITS(VALUE_BITS), .TIME_BITS(TIME_BITS)) u_out (
      .clock(clock), .reset(reset), .wr_en(wr_en), .wr_mask(wr_mask),
      .wr_time(out_time), .wr_value(out_value), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_kept_time(rsp_kept_time),
      .rsp_kept_value(rsp_kept_value), .rsp_series_done(rsp_series_done),
      .retire(retire));

endmodule

### rtl/wsor_checker.sv
module wsor_checker
   import wsor_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic        [TIME_BITS-1:0]  req_sample_time,
   input logic signed [VALUE_BITS-1:0] req_sample_value,
   input logic                         req_end_of_series,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic        [TIME_BITS-1:0]  rsp_kept_time,
   input logic signed [VALUE_BITS-1:0] rsp_kept_value,
   input logic                         rsp_series_done
);

   logic         end_beat, done_beat;
   logic [QAW:0] ends_ff, ends_in;

   // series ends taken but not yet closed by a done beat
   always_comb begin
      end_beat  = req_valid && req_ready && req_end_of_series;
      done_beat = rsp_valid && rsp_ready && rsp_series_done;
      ends_in   = ends_ff + (QAW+1)'(end_beat) - (QAW+1)'(done_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) ends_ff <= '0;
      else       ends_ff <= ends_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before its beat was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kept_time) && $stable(rsp_kept_value)
                                  && $stable(rsp_series_done))
      else $error("result payload changed while stalled");

   a_done_has_end: assert property (@(posedge clock) disable iff (reset)
      done_beat |-> ends_ff != '0)
      else $error("series_done without a matching series end");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind window_sigma_outlier_reject wsor_checker #(
   .VALUE_BITS(VALUE_BITS),
   .TIME_BITS(TIME_BITS)
) u_wsor_checker (.*);
